@@ rtl/arca_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// arca_pkg: shared constants and types for the address region claim allocator
// Holds the command codes, the table entry layout, the default capacity and the CSR addresses.
// ----------------------------------------------------------------------------
package arca_pkg;

   localparam int unsigned CapacityDefault = 64;

   typedef enum logic [1:0] {
      CMD_CLAIM = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2,
      CMD_SPARE = 2'd3
   } cmd_type;

   // one table entry as stored in the RAM, used flag in the top bit
   typedef struct packed {
      logic        used;
      logic [7:0]  kind;
      logic [63:0] size;
      logic [63:0] base;
   } entry_type;

   localparam int unsigned EntryWidth = $bits(entry_type);

   localparam logic [3:0] REG_WINDOW_LOW  = 4'd0;
   localparam logic [3:0] REG_WINDOW_HIGH = 4'd8;

endpackage : arca_pkg
`default_nettype wire

@@ rtl/arca_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// arca_ram: generic single-port RAM
// Each cycle the addressed word is read and, when wr_en is high, also written; read data registered.
// ----------------------------------------------------------------------------
module arca_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   output logic      [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule : arca_ram
`default_nettype wire

@@ rtl/address_region_claim_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// address_region_claim_allocator: table of address-range claims
// Claim, lowest-base-fit alloc and free over an append-only table held in one RAM.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  req_     in   tdata: command[1:0] address[65:2] length[129:66] region_kind[137:130]
//  rsp_     out  tdata: ok[0] placed_base[64:1]
//  csr_     in   APB, window_low at 0x0, window_high at 0x8 (64-bit data)
//
// Claim and free sweep the filled slots once. Alloc sweeps once per
// candidate (window_low, then each slot), one slot read at a time through
// the single RAM read port. No clearing pass: only filled slots are ever
// read. One item at a time; req_tready is low while an item is at work or
// its result waits on rsp_.
module address_region_claim_allocator
   import arca_pkg::*;
#(
   parameter int unsigned CAPACITY = CapacityDefault
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [143:0]  req_tdata,   // command, address, length, region_kind
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [71:0]        rsp_tdata,   // ok, placed_base
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [3:0]    csr_paddr,
   input  wire logic [63:0]   csr_pwdata,
   output logic [63:0]        csr_prdata,
   output logic               csr_pready
);
   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CapFull = CW'(CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CAND, ST_SCAN, ST_DECIDE, ST_WRITE, ST_RESP
   } state_type;

   state_type      state_ff, state_in;
   logic [63:0]    win_lo_ff, win_hi_ff;
   cmd_type        cmd_ff;
   logic [63:0]    addr_ff, len_ff;
   logic [7:0]     kind_ff;
   logic [CW-1:0]  filled_ff, filled_in;
   logic [CW-1:0]  idx_ff, idx_in;       // scan index
   logic [CW-1:0]  cidx_ff, cidx_in;     // candidate source, 0 = window_low
   logic           rd_ok_ff, rd_ok_in;   // RAM output belongs to idx_ff-1
   logic [63:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic           hit_ff, hit_in, bad_ff, bad_in;
   logic           found_ff, found_in;
   logic [63:0]    best_ff, best_in;
   logic [AW-1:0]  free_slot_ff, free_slot_in;
   logic           ok_ff, ok_in;
   logic [63:0]    placed_ff, placed_in;

   logic           ram_we;
   logic [AW-1:0]  ram_addr;
   entry_type      ram_wd, ram_rd;
   logic [CW-1:0]  prev_idx;
   logic [63:0]    ent_end, cand_s, cand_e;

   arca_ram #(.WIDTH(EntryWidth), .DEPTH(CAPACITY)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wd),
      .rd_data (ram_rd)
   );

   // configuration port
   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr)
         REG_WINDOW_LOW:  csr_prdata = win_lo_ff;
         REG_WINDOW_HIGH: csr_prdata = win_hi_ff;
         default:         csr_prdata = '0;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = {7'd0, placed_ff, ok_ff};
   assign ent_end    = ram_rd.base + ram_rd.size;
   assign prev_idx   = idx_ff - CW'(1);

   // candidate start from the entry just read
   always_comb begin
      cand_s = (ent_end < win_lo_ff) ? win_lo_ff : ent_end;
      cand_e = cand_s + len_ff;
   end

   // sequencer: next-state and datapath
   always_comb begin
      state_in = state_ff; filled_in = filled_ff; idx_in = idx_ff;
      cidx_in = cidx_ff; rd_ok_in = 1'b0; lo_in = lo_ff; hi_in = hi_ff;
      hit_in = hit_ff; bad_in = bad_ff; found_in = found_ff; best_in = best_ff;
      free_slot_in = free_slot_ff; ok_in = ok_ff; placed_in = placed_ff;
      ram_we = 1'b0; ram_addr = idx_ff[AW-1:0]; ram_wd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0; cidx_in = '0; hit_in = 1'b0; found_in = 1'b0;
            best_in = '0;
            if (req_tvalid) begin
               if (cmd_type'(req_tdata[1:0]) == CMD_ALLOC) begin
                  lo_in  = win_lo_ff;
                  hi_in  = win_lo_ff + req_tdata[129:66];
                  bad_in = (hi_in < win_lo_ff) || (hi_in > win_hi_ff);
               end else begin
                  lo_in  = req_tdata[65:2];
                  hi_in  = req_tdata[65:2] + req_tdata[129:66];
                  bad_in = 1'b0;
               end
               state_in = ST_SCAN;
            end
         end
         ST_CAND: begin
            // entry cidx-1 was read; derive its end as a candidate
            if (rd_ok_ff) begin
               lo_in = cand_s; hi_in = cand_e;
               bad_in = !ram_rd.used || (cand_e < cand_s) || (cand_e > win_hi_ff);
               hit_in = 1'b0; idx_in = '0; state_in = ST_SCAN;
            end else begin
               ram_addr = prev_idx[AW-1:0];
               rd_ok_in = 1'b1;
            end
         end
         ST_SCAN: begin
            if (rd_ok_ff && ram_rd.used) begin
               if (cmd_ff == CMD_FREE) begin
                  if (!hit_ff && ram_rd.base == addr_ff) begin
                     hit_in = 1'b1; free_slot_in = prev_idx[AW-1:0];
                  end
               end else if (lo_ff < ent_end && ram_rd.base < hi_ff) begin
                  hit_in = 1'b1;
               end
            end
            if (idx_ff < filled_ff) begin
               rd_ok_in = 1'b1; idx_in = idx_ff + CW'(1);
            end else if (!rd_ok_ff || idx_ff == filled_ff) begin
               state_in = ST_DECIDE;
            end
            if (!(idx_ff < filled_ff) && rd_ok_ff) state_in = ST_SCAN;
            if (!(idx_ff < filled_ff) && !rd_ok_ff) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (cmd_ff == CMD_ALLOC) begin
               if (!bad_ff && !hit_ff && (!found_ff || lo_ff < best_ff)) begin
                  found_in = 1'b1; best_in = lo_ff;
               end
               if (cidx_ff < filled_ff) begin
                  cidx_in = cidx_ff + CW'(1); idx_in = cidx_ff + CW'(1);
                  state_in = ST_CAND;
               end else begin
                  ok_in = found_in && (filled_ff < CapFull);
                  placed_in = ok_in ? best_in : '0;
                  lo_in = best_in; hi_in = best_in + len_ff;
                  state_in = ok_in ? ST_WRITE : ST_RESP;
               end
            end else if (cmd_ff == CMD_FREE) begin
               ok_in = hit_ff; placed_in = '0;
               state_in = hit_ff ? ST_WRITE : ST_RESP;
            end else begin
               ok_in = !hit_ff && (filled_ff < CapFull); placed_in = '0;
               lo_in = addr_ff;
               state_in = ok_in ? ST_WRITE : ST_RESP;
            end
         end
         ST_WRITE: begin
            ram_we = 1'b1;
            if (cmd_ff == CMD_FREE) begin
               ram_addr = free_slot_ff;
               ram_wd = '{used: 1'b0, kind: 8'd0, size: 64'd0, base: addr_ff};
            end else begin
               ram_addr = filled_ff[AW-1:0];
               ram_wd = '{used: 1'b1, kind: kind_ff, size: len_ff, base: lo_ff};
               filled_in = filled_ff + CW'(1);
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; filled_ff <= '0; win_lo_ff <= '0; win_hi_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in; filled_ff <= filled_in; rd_ok_ff <= rd_ok_in;
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr == REG_WINDOW_LOW)  win_lo_ff <= csr_pwdata;
            if (csr_paddr == REG_WINDOW_HIGH) win_hi_ff <= csr_pwdata;
         end
      end
      if (state_ff == ST_IDLE && req_tvalid) begin
         cmd_ff  <= (cmd_type'(req_tdata[1:0]) == CMD_SPARE) ? CMD_CLAIM
                                                            : cmd_type'(req_tdata[1:0]);
         addr_ff <= req_tdata[65:2];
         len_ff  <= req_tdata[129:66];
         kind_ff <= req_tdata[137:130];
      end
      idx_ff <= idx_in; cidx_ff <= cidx_in; lo_ff <= lo_in; hi_ff <= hi_in;
      hit_ff <= hit_in; bad_ff <= bad_in; found_ff <= found_in; best_ff <= best_in;
      free_slot_ff <= free_slot_in; ok_ff <= ok_in; placed_ff <= placed_in;
   end

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CapFull) else $error("slot count beyond capacity");
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      filled_ff != $past(filled_ff) |-> $past(state_ff) == ST_WRITE)
      else $error("slot count moved outside a write");
   a_placed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !ok_ff |-> placed_ff == 64'd0)
      else $error("rejected item with nonzero base");
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while result pending");
endmodule : address_region_claim_allocator
`default_nettype wire
